/* hw/rtl/eltt_pkg.sv */
// Package: shared constants and types for the exclusive line tracking table
`timescale 1ns / 1ps
package eltt_pkg;
    localparam int DEPTH_DEF = 1024;
    localparam int TAG_W     = 58;
    localparam int CNT_W     = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    localparam logic [1:0] ACT_TRACK   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RECOVER = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // slot word: valid, exclusive held, fallback needed, tag
    typedef struct packed {
        logic             valid;
        logic             excl;
        logic             fallback;
        logic [TAG_W-1:0] tag;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DONE
    } state_t;
endpackage

/* hw/rtl/eltt_mem.sv */
// Slot memory: one write port, one registered read port
`timescale 1ns / 1ps
module eltt_mem #(
    parameter int DEPTH = eltt_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  eltt_pkg::slot_t      wdata,
    input  logic [AW-1:0]        raddr,
    output eltt_pkg::slot_t      rdata
);
    eltt_pkg::slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/exclusive_line_tracking_table_core.sv */
// Top level: exclusive line tracking table with scan sequencer
`timescale 1ns / 1ps
// Exclusive line tracking table.
// Command channel: action, line_address, want_exclusive are taken at a rising
// edge with start high and busy low. Each command yields one result, shown for
// one cycle with done high: status, slot_index, recovered_lines,
// exclusive_lines. The receiver cannot stall; results are never held back.
// Track, release and recover scan the slot memory one slot a cycle through its
// single registered read port; the unused action code goes straight to the
// result. Track stops at the first free slot, release at the first match,
// recover walks the whole table. Busy drops the cycle after the result. Scan
// read and write-back are one slot apart, so no slot is read after a pending
// write to it. After reset the block runs a clearing pass, writing every slot
// invalid, with busy high. The exclusive-line count and the internal recovered
// total reset to zero; recovered_lines is cleared when a command is accepted.
module exclusive_line_tracking_table_core #(
    parameter int DEPTH = eltt_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] line_address,
    input  logic        want_exclusive,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  slot_index,
    output logic [10:0] recovered_lines,
    output logic [10:0] exclusive_lines
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    eltt_pkg::state_t state_reg, state_next;
    logic [CW-1:0] rptr_reg, rptr_next;   // next read address
    logic [CW-1:0] cptr_reg, cptr_next;   // address of rdata
    logic          rv_reg, rv_next;       // rdata valid
    logic [1:0]    act_reg, act_next;
    logic [eltt_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic          wex_reg, wex_next;
    logic [eltt_pkg::CNT_W-1:0] excnt_reg, excnt_next;
    logic [eltt_pkg::CNT_W-1:0] rec_reg, rec_next;
    logic [63:0]   rtot_reg, rtot_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] slot_reg, slot_next;

    logic            we;
    logic [AW-1:0]   waddr;
    eltt_pkg::slot_t wdata, rdata;

    eltt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(rptr_reg[AW-1:0]), .rdata(rdata)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eltt_pkg::S_CLEAR;
            rptr_reg  <= '0;
            cptr_reg  <= '0;
            rv_reg    <= 1'b0;
            excnt_reg <= '0;
            rtot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rptr_reg  <= rptr_next;
            cptr_reg  <= cptr_next;
            rv_reg    <= rv_next;
            excnt_reg <= excnt_next;
            rtot_reg  <= rtot_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        tag_reg  <= tag_next;
        wex_reg  <= wex_next;
        rec_reg  <= rec_next;
        st_reg   <= st_next;
        slot_reg <= slot_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rptr_next  = rptr_reg;
        cptr_next  = rptr_reg;
        rv_next    = 1'b0;
        act_next   = act_reg;
        tag_next   = tag_reg;
        wex_next   = wex_reg;
        excnt_next = excnt_reg;
        rec_next   = rec_reg;
        rtot_next  = rtot_reg;
        st_next    = st_reg;
        slot_next  = slot_reg;
        we         = 1'b0;
        waddr      = cptr_reg[AW-1:0];
        wdata      = '0;
        unique case (state_reg)
            eltt_pkg::S_CLEAR:
            begin
                we    = 1'b1;
                waddr = rptr_reg[AW-1:0];
                rptr_next = rptr_reg + 1'b1;
                if (rptr_reg == DEPTH_C - 1'b1)
                begin
                    rptr_next  = '0;
                    state_next = eltt_pkg::S_IDLE;
                end
            end
            eltt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    tag_next  = line_address[63:6];
                    wex_next  = want_exclusive;
                    rec_next  = '0;
                    slot_next = '0;
                    rptr_next = '0;
                    if (action == eltt_pkg::ACT_TRACK || action == eltt_pkg::ACT_RELEASE
                        || action == eltt_pkg::ACT_RECOVER)
                    begin
                        st_next    = (action == eltt_pkg::ACT_TRACK) ? eltt_pkg::ST_FULL :
                                     (action == eltt_pkg::ACT_RELEASE) ?
                                     eltt_pkg::ST_NOMATCH : eltt_pkg::ST_DONE;
                        rptr_next  = CW'(1);
                        rv_next    = 1'b1;
                        cptr_next  = '0;
                        state_next = eltt_pkg::S_SCAN;
                    end
                    else
                    begin
                        st_next    = eltt_pkg::ST_DONE;
                        state_next = eltt_pkg::S_DONE;
                    end
                end
            end
            eltt_pkg::S_SCAN:
            begin
                // issue next read; handle slot at cptr
                rptr_next = rptr_reg + 1'b1;
                rv_next   = (rptr_reg < DEPTH_C);
                if (rv_reg)
                begin
                    priority case (act_reg)
                        eltt_pkg::ACT_TRACK:
                        begin
                            if (!rdata.valid)
                            begin
                                we          = 1'b1;
                                wdata.valid = 1'b1;
                                wdata.excl  = wex_reg;
                                wdata.tag   = tag_reg;
                                st_next     = eltt_pkg::ST_DONE;
                                slot_next   = cptr_reg[AW-1:0];
                                if (wex_reg && excnt_reg != eltt_pkg::CNT_MAX)
                                begin
                                    excnt_next = excnt_reg + 1'b1;
                                end
                                state_next = eltt_pkg::S_DONE;
                            end
                        end
                        eltt_pkg::ACT_RELEASE:
                        begin
                            if (rdata.valid && rdata.tag == tag_reg)
                            begin
                                we        = 1'b1;
                                st_next   = eltt_pkg::ST_DONE;
                                slot_next = cptr_reg[AW-1:0];
                                if (rdata.excl && excnt_reg != '0)
                                begin
                                    excnt_next = excnt_reg - 1'b1;
                                end
                                state_next = eltt_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            if (rdata.valid && rdata.excl)
                            begin
                                we             = 1'b1;
                                wdata          = rdata;
                                wdata.excl     = 1'b0;
                                wdata.fallback = 1'b1;
                                if (rec_reg != eltt_pkg::CNT_MAX)
                                begin
                                    rec_next = rec_reg + 1'b1;
                                end
                                rtot_next = rtot_reg + 64'd1;
                            end
                        end
                    endcase
                    if (cptr_reg == DEPTH_C - 1'b1)
                    begin
                        state_next = eltt_pkg::S_DONE;
                    end
                end
            end
            eltt_pkg::S_DONE:
            begin
                // next command reads slot 0 first
                rptr_next  = '0;
                state_next = eltt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = eltt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != eltt_pkg::S_IDLE);
    assign done            = (state_reg == eltt_pkg::S_DONE);
    assign status          = st_reg;
    assign slot_index      = 10'(slot_reg);
    assign recovered_lines = rec_reg;
    assign exclusive_lines = excnt_reg;
endmodule

/* sim/exclusive_line_tracking_table_core_tb.sv */
// Testbench for the exclusive line tracking table core: directed and random checks
`timescale 1ns / 1ps
module exclusive_line_tracking_table_core_tb;

    localparam int          SLOTS      = eltt_pkg::DEPTH_DEF;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam int          LIMIT      = 30000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [10:0] recovered;
        logic [10:0] excl_count;
    } line_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [63:0] line_address;
    logic        want_exclusive;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic [10:0] recovered_lines;
    logic [10:0] exclusive_lines;

    // shadow copy of the tracking table
    logic                       trk_valid [SLOTS];
    logic [eltt_pkg::TAG_W-1:0] trk_tag   [SLOTS];
    logic                       trk_held  [SLOTS];
    logic [eltt_pkg::CNT_W-1:0] trk_excl_count;

    line_result_t pending_results[$];
    logic [63:0]  live_lines[$];
    int           mismatches;
    int           cycle_count;
    bit           no_idle;

    exclusive_line_tracking_table_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .line_address(line_address),
        .want_exclusive(want_exclusive), .done(done), .status(status),
        .slot_index(slot_index), .recovered_lines(recovered_lines),
        .exclusive_lines(exclusive_lines)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // predict the result of one action and update the shadow table
    function automatic line_result_t track_table_step(logic [1:0] act, logic [63:0] addr,
                                                      logic excl);
        line_result_t r;
        logic [eltt_pkg::TAG_W-1:0] tg;
        int s;
        r  = '0;
        tg = addr[63:6];
        if (act == eltt_pkg::ACT_TRACK) begin
            r.status = eltt_pkg::ST_FULL;
            for (s = 0; s < SLOTS; s++)
            begin
                if (!trk_valid[s])
                begin
                    r.status     = eltt_pkg::ST_DONE;
                    r.slot       = s[9:0];
                    trk_valid[s] = 1'b1;
                    trk_tag[s]   = tg;
                    trk_held[s]  = excl;
                    if (excl && trk_excl_count != eltt_pkg::CNT_MAX)
                        trk_excl_count++;
                    break;
                end
            end
        end
        else if (act == eltt_pkg::ACT_RELEASE) begin
            r.status = eltt_pkg::ST_NOMATCH;
            for (s = 0; s < SLOTS; s++)
            begin
                if (trk_valid[s] && trk_tag[s] == tg)
                begin
                    if (trk_held[s] && trk_excl_count != 0)
                        trk_excl_count--;
                    trk_valid[s] = 1'b0;
                    trk_held[s]  = 1'b0;
                    r.status     = eltt_pkg::ST_DONE;
                    r.slot       = s[9:0];
                    break;
                end
            end
        end
        else if (act == eltt_pkg::ACT_RECOVER) begin
            for (s = 0; s < SLOTS; s++)
            begin
                if (trk_valid[s] && trk_held[s])
                begin
                    trk_held[s] = 1'b0;
                    if (r.recovered != eltt_pkg::CNT_MAX)
                        r.recovered++;
                end
            end
        end
        r.excl_count = trk_excl_count;
        return r;
    endfunction

    function automatic int free_slots();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (!trk_valid[s])
                n++;
        return n;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // one command transfer; start is held across back-to-back transfers
    task automatic send_action(logic [1:0] act, logic [63:0] addr, logic excl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        action         <= act;
        line_address   <= addr;
        want_exclusive <= excl;
        do @(posedge clk); while (busy);
        pending_results.push_back(track_table_step(act, addr, excl));
    endtask

    function automatic logic [63:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'({status, slot_index}), 64'd0);
            else begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (slot_index !== want.slot)
                    report_mismatch("slot_index", 64'(slot_index), 64'(want.slot));
                if (recovered_lines !== want.recovered)
                    report_mismatch("recovered_lines", 64'(recovered_lines),
                                    64'(want.recovered));
                if (exclusive_lines !== want.excl_count)
                    report_mismatch("exclusive_lines", 64'(exclusive_lines),
                                    64'(want.excl_count));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // edges of fields, duplicates, misses, unused code, recover then release
    task automatic test_directed();
        no_idle = 1'b0;
        send_action(eltt_pkg::ACT_TRACK, 64'h0, 1'b1);
        send_action(eltt_pkg::ACT_TRACK, '1, 1'b0);
        send_action(eltt_pkg::ACT_TRACK, 64'h0000_0000_0000_1000, 1'b1);
        send_action(eltt_pkg::ACT_TRACK, 64'h0000_0000_0000_103F, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'h0000_0000_0000_0040, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFC0, 1'b1);
        send_action(eltt_pkg::ACT_RELEASE, 64'h0000_0000_0000_1027, 1'b0);
        send_action(ACT_UNUSED, '1, 1'b1);
        send_action(eltt_pkg::ACT_RECOVER, 64'h0, 1'b0);
        send_action(eltt_pkg::ACT_RECOVER, 64'h0, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'h0000_0000_0000_0015, 1'b0);
        send_action(eltt_pkg::ACT_TRACK, 64'h8000_0000_0000_0000, 1'b1);
        send_action(eltt_pkg::ACT_TRACK, 64'h5555_5555_5555_5555, 1'b1);
        send_action(eltt_pkg::ACT_TRACK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'h8000_0000_0000_003F, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'h0000_0000_0000_1000, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'h0000_0000_0000_1000, 1'b0);
        send_action(ACT_UNUSED, 64'h0, 1'b0);
        send_action(eltt_pkg::ACT_RECOVER, '1, 1'b1);
        send_action(eltt_pkg::ACT_RELEASE, 64'h5555_5555_5555_5540, 1'b0);
        send_action(eltt_pkg::ACT_RELEASE, 64'hAAAA_AAAA_AAAA_AA80, 1'b1);
    endtask

    // random mix biased towards releasing lines that are tracked
    task automatic test_random(int items);
        int pick;
        int k;
        logic [63:0] a;
        for (int i = 0; i < items; i++)
        begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (live_lines.size() > 48 && pick < 45)
                pick = 50;
            if (pick < 40) begin
                if (live_lines.size() > 0 && $urandom_range(0, 9) == 0)
                    a = live_lines[$urandom_range(0, live_lines.size() - 1)];
                else
                    a = rand_addr();
                live_lines.push_back(a);
                send_action(eltt_pkg::ACT_TRACK, a, 1'($urandom_range(0, 1)));
            end
            else if (pick < 75 && live_lines.size() > 0) begin
                k = $urandom_range(0, live_lines.size() - 1);
                a = live_lines[k];
                live_lines.delete(k);
                a[5:0] = 6'($urandom_range(0, 63));
                send_action(eltt_pkg::ACT_RELEASE, a, 1'($urandom_range(0, 1)));
            end
            else if (pick < 85)
                send_action(eltt_pkg::ACT_RELEASE, rand_addr(), 1'($urandom_range(0, 1)));
            else if (pick < 93)
                send_action(eltt_pkg::ACT_RECOVER, rand_addr(), 1'($urandom_range(0, 1)));
            else
                send_action(ACT_UNUSED, rand_addr(), 1'($urandom_range(0, 1)));
        end
    endtask

    // fill the table, hit full, then drift the exclusive counter to saturation
    task automatic test_full_and_saturation();
        int n;
        int rounds;
        no_idle = 1'b1;
        n = free_slots();
        repeat (n) send_action(eltt_pkg::ACT_TRACK, rand_addr(), 1'b1);
        send_action(eltt_pkg::ACT_TRACK, rand_addr(), 1'b1);
        send_action(eltt_pkg::ACT_TRACK, rand_addr(), 1'b0);
        send_action(eltt_pkg::ACT_RECOVER, 64'h0, 1'b0);
        no_idle = 1'b0;
        rounds = 0;
        while (rounds < 40)
        begin
            for (int s = 0; s < 64; s++)
                send_action(eltt_pkg::ACT_RELEASE, {trk_tag[s], 6'(s)}, 1'b0);
            repeat (64) send_action(eltt_pkg::ACT_TRACK, rand_addr(), 1'b1);
            send_action(eltt_pkg::ACT_RECOVER, 64'h0, 1'b0);
            if (trk_excl_count == eltt_pkg::CNT_MAX)
                rounds = rounds < 38 ? 38 : rounds + 1;
            else
                rounds++;
        end
        // counter drops from saturation on releasing held lines
        for (int s = 0; s < 4; s++)
            send_action(eltt_pkg::ACT_RELEASE, {trk_tag[s], 6'h3F}, 1'b1);
        repeat (4) send_action(eltt_pkg::ACT_TRACK, rand_addr(), 1'b1);
        for (int s = 0; s < 4; s++)
            send_action(eltt_pkg::ACT_RELEASE, {trk_tag[s], 6'h00}, 1'b0);
    endtask

    initial
    begin
        int wait_cycles;
        mismatches     = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = eltt_pkg::ACT_TRACK;
        line_address   = '0;
        want_exclusive = 1'b0;
        trk_excl_count = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            trk_valid[s] = 1'b0;
            trk_tag[s]   = '0;
            trk_held[s]  = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(580);
        test_full_and_saturation();

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/eltt_pkg.sv
hw/rtl/eltt_mem.sv
hw/rtl/exclusive_line_tracking_table_core.sv
sim/exclusive_line_tracking_table_core_tb.sv
